// ===== rtl/cmbe_pkg.sv =====
// Shared types, constants and the CRC byte step for the masked CRC-32 engine.
package cmbe_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [CrcWidth-1:0] CrcPolyReflected = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0] MaskReset        = 32'hD202_EF8D;
    localparam logic [CrcWidth-1:0] CrcSeed          = '0;

    typedef logic [CrcWidth-1:0]  t_crc;
    typedef logic [ByteWidth-1:0] t_byte;

    // One message byte held in the input stage.
    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_beat;

    // Reflected CRC-32 update by one byte, eight shift and conditional XOR rounds.
    function automatic t_crc crc_byte_step(input t_crc crc, input t_byte data);
        t_crc r;
        r = {{(CrcWidth-ByteWidth){1'b0}}, crc[ByteWidth-1:0] ^ data};
        for (int k = 0; k < ByteWidth; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CrcPolyReflected;
            end else begin
                r = r >> 1;
            end
        end
        return r ^ (crc >> ByteWidth);
    endfunction

endpackage

// ===== rtl/cmbe_fold.sv =====
// Running CRC register, byte fold and result register of the masked CRC-32 engine.
module cmbe_fold (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_beat_valid,
    input  cmbe_pkg::t_beat i_beat,
    input  cmbe_pkg::t_crc i_mask,
    input  logic           i_out_stall,
    output logic           o_fire,
    output logic           o_out_valid,
    output cmbe_pkg::t_crc o_crc_value
);

    cmbe_pkg::t_crc r_crc;
    cmbe_pkg::t_crc n_crc;
    cmbe_pkg::t_crc r_out_crc;
    logic           r_out_valid;
    logic           out_free;
    cmbe_pkg::t_crc folded;

    // Fold the byte, then apply the mask.
    assign folded = cmbe_pkg::crc_byte_step(r_crc, i_beat.data_byte) ^ i_mask;

    // Take a beat unless it ends a message and the result slot is still held.
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_fire   = i_beat_valid && (!i_beat.last_byte || out_free);

    always_comb begin
        n_crc = r_crc;
        if (o_fire) begin
            n_crc = i_beat.last_byte ? cmbe_pkg::CrcSeed : folded;
        end
    end

    // Advance the running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= cmbe_pkg::CrcSeed;
        end else begin
            r_crc <= n_crc;
        end
    end

    // Load the result register when it is free; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_fire && i_beat.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && o_fire && i_beat.last_byte) begin
            r_out_crc <= folded;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    // A finished message leaves the register at the seed and a result waiting.
    a_seed_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire && i_beat.last_byte |=> r_crc == cmbe_pkg::CrcSeed)
        else $error("running CRC not cleared after last beat");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire && i_beat.last_byte |=> r_out_valid)
        else $error("no result after last beat");

    a_crc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_fire |=> $stable(r_crc))
        else $error("running CRC moved without a beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && i_beat_valid && i_beat.last_byte |-> !o_fire)
        else $error("last beat taken while result slot held");

endmodule

// ===== rtl/crc32_masked_byte_engine.sv =====
// Top level of the masked CRC-32 byte engine: input stage, mask register and fold.
//
// The engine takes one message byte per cycle while its input is not
// stalled and keeps a reflected CRC-32 (polynomial 0xEDB88320) that starts
// at zero for every message; after each byte the running value is XORed with
// the mask register (reset 0xD202EF8D). The beat flagged last yields one
// result carrying the masked CRC of the whole message, and the next beat
// starts a new message. A beat is held in the input register, where it is
// folded into the running CRC; its result, if any, is loaded into the result
// register at the end of the folding cycle and is presented in the next.
// Throughput is one byte per cycle while the input is not stalled, limited
// by the combinational eight-round byte fold that feeds the running CRC
// register back on itself. A held result stalls the input only when another
// last beat arrives behind it. Write the mask only while no message is in flight.
module crc32_masked_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_crc_value,
    // mask write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic            r_in_valid;
    logic            n_in_valid;
    cmbe_pkg::t_beat r_beat;
    cmbe_pkg::t_crc  r_mask;
    logic            fire;
    logic            in_accept;

    // Take a mask write in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= cmbe_pkg::MaskReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    // Input register: refill in the same cycle the held beat is folded.
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_beat.data_byte <= i_data_byte;
            r_beat.last_byte <= i_last_byte;
        end
    end

    cmbe_fold u_fold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (r_in_valid),
        .i_beat       (r_beat),
        .i_mask       (r_mask),
        .i_out_stall  (i_out_stall),
        .o_fire       (fire),
        .o_out_valid  (o_out_valid),
        .o_crc_value  (o_crc_value)
    );

endmodule

// ===== tb/tb.sv =====
// Testbench for the masked CRC-32 byte engine: scoreboard class, stimulus tasks and checks.
module tb;

    // Expected CRC results, predicted from every accepted byte beat
    class crc_scoreboard;
        cmbe_pkg::t_crc byte_mask;
        cmbe_pkg::t_crc running_crc;
        cmbe_pkg::t_crc expected_crcs[$];
        int             error_count;

        function new();
            byte_mask   = cmbe_pkg::MaskReset;
            running_crc = cmbe_pkg::CrcSeed;
            error_count = 0;
        endfunction

        function void set_mask(input cmbe_pkg::t_crc value);
            byte_mask = value;
        endfunction

        // Fold one accepted byte bit-serially, LSB first, then apply the mask
        function void note_byte(input cmbe_pkg::t_byte data, input logic is_last);
            cmbe_pkg::t_crc crc;
            logic feedback;
            crc = running_crc;
            for (int i = 0; i < cmbe_pkg::ByteWidth; i++) begin
                feedback = crc[0] ^ data[i];
                crc      = crc >> 1;
                if (feedback) begin
                    crc = crc ^ cmbe_pkg::CrcPolyReflected;
                end
            end
            crc = crc ^ byte_mask;
            if (is_last) begin
                expected_crcs.push_back(crc);
                running_crc = cmbe_pkg::CrcSeed;
            end else begin
                running_crc = crc;
            end
        endfunction

        // Compare one accepted result beat with the oldest expected CRC
        function void check_crc(input cmbe_pkg::t_crc actual);
            cmbe_pkg::t_crc expected;
            if (expected_crcs.size() == 0) begin
                $display("%0t: unexpected crc result %08h, none expected", $time, actual);
                error_count++;
                return;
            end
            expected = expected_crcs.pop_front();
            if (actual !== expected) begin
                $display("%0t: crc_value mismatch: expected %08h, actual %08h",
                         $time, expected, actual);
                error_count++;
            end
        endfunction
    endclass

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_crc_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;

    crc_scoreboard sb;
    int            burst_left = 0;
    t_stall_mode   stall_mode = STALL_NONE;
    int            stall_left = 0;

    crc32_masked_byte_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_crc_value (o_crc_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop for a hung run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver stall: switch among stall patterns, holding each for a random span
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_out_stall <= ($urandom_range(0, 4) != 0);
            end
            default: begin
                i_out_stall <= stall_left[2];
            end
        endcase
    end

    // Watch both channels; values read here are the ones present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_byte(i_data_byte, i_last_byte);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_crc(o_crc_value);
        end
    end

    // Drive one byte beat, opening a gap first when the current burst is spent
    task automatic send_beat(input cmbe_pkg::t_byte data, input logic is_last);
        if (burst_left == 0) begin
            i_in_valid  <= 1'b0;
            i_data_byte <= cmbe_pkg::t_byte'($urandom);
            i_last_byte <= 1'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_beat(cmbe_pkg::t_byte'($urandom), (i == len - 1));
        end
    endtask

    // Drop valid, let the monitor note the final beat, then wait for every
    // expected result to be checked
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_crcs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mask(input cmbe_pkg::t_crc value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_mask(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Random messages, mostly short, now and then long
    task automatic random_phase(input int n_bytes);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = $urandom_range(1, 4);
            end else if (pick < 19) begin
                len = $urandom_range(5, 12);
            end else begin
                len = $urandom_range(13, 40);
            end
            send_message(len);
            sent += len;
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mask: single-byte messages at the byte extremes, then a short message
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h80, 1'b1);
        send_beat(8'h01, 1'b1);
        send_beat(8'h12, 1'b0);
        send_beat(8'h34, 1'b0);
        send_beat(8'h56, 1'b0);
        send_beat(8'h78, 1'b1);
        drain();

        // Zero mask: plain CRC, zero bytes must give zero
        write_mask(32'h0000_0000);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        drain();

        // All-ones mask
        write_mask(32'hFFFF_FFFF);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        drain();

        // Random traffic under a series of mask settings
        write_mask(cmbe_pkg::t_crc'($urandom));
        random_phase(100);
        write_mask(32'h0000_0000);
        random_phase(100);
        write_mask(32'hFFFF_FFFF);
        random_phase(100);
        write_mask(cmbe_pkg::t_crc'($urandom));
        random_phase(100);
        write_mask(cmbe_pkg::MaskReset);
        random_phase(100);

        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_crcs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.expected_crcs.size() != 0) begin
                $display("%0t: %0d expected crc results never arrived",
                         $time, sb.expected_crcs.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
